// ===== design/hcb_pkg.sv =====
// Shared constants and field widths for the Huffman code builder.
package hcb_pkg;

	localparam int WEIGHT_W  = 12;
	localparam int VALUE_W   = 16;
	localparam int INDEX_W   = 5;
	localparam int CODE_W    = 31;
	localparam int LENGTH_W  = 5;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 64;

	// Input kinds carried on s_axis_tuser
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_BUILD = 1'b1;

	// Bit positions of the result fields in m_axis_tdata
	localparam int OFS_VALUE  = INDEX_W;
	localparam int OFS_CODE   = OFS_VALUE + VALUE_W;
	localparam int OFS_LENGTH = OFS_CODE + CODE_W;
	localparam int OFS_EMPTY  = OFS_LENGTH + LENGTH_W;
	localparam int OFS_OVF    = OFS_EMPTY + 1;

endpackage

// ===== design/huffman_code_builder.sv =====
// Huffman code builder: leaf loading, tree construction and code emission.
//
// A load item (tuser = 0) stores one leaf; leaves beyond MAX_LEAVES are
// dropped and flagged. A build item (tuser = 1) merges the two lightest
// parentless nodes repeatedly, each merge being one pass of the shared
// compare unit over the node-weight RAM (one node per cycle), then emits one
// code per leaf in leaf order; a build with no leaves emits a single item
// flagged no_leaves. Each code is found by walking from the leaf to the root
// through the parent RAM, one tree level at a time, and is then offered
// through the output handshake. The input side is not ready during a build
// or while a result waits. Ties in weight go to the lower node index; the
// first pick becomes the left child (code bit 0), the second the right child
// (code bit 1).
module huffman_code_builder
	import hcb_pkg::*;
#(
	parameter int MAX_LEAVES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tdata: leaf_weight[11:0], leaf_value[27:12], zero fill
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// tuser: action
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// tdata: leaf_index[4:0], symbol_value[20:5], code_bits[51:21],
	// code_length[56:52], no_leaves[57], overflowed[58], zero fill
	output logic [M_DATA_W-1:0] m_axis_tdata,
	output logic                m_axis_tlast
);

	localparam int NODES = 2 * MAX_LEAVES - 1;
	localparam int NW    = $clog2(2 * MAX_LEAVES);
	localparam int LW    = $clog2(MAX_LEAVES);
	localparam int CW    = $clog2(MAX_LEAVES + 1);
	localparam int WW    = WEIGHT_W + $clog2(MAX_LEAVES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_MERGE = 3'd2;
	localparam logic [2:0] ST_MRG2  = 3'd3;
	localparam logic [2:0] ST_LEAF  = 3'd4;
	localparam logic [2:0] ST_WRD   = 3'd5;
	localparam logic [2:0] ST_WUSE  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [NW-1:0] made_q;
	logic [NW-1:0] target_q;
	logic [NW-1:0] addr_q;
	logic [NW-1:0] didx_q;
	logic          pend_q;
	logic          bvld_q, svld_q;
	logic [NW-1:0] bidx_q, sidx_q;
	logic [WW-1:0] bw_q, sw_q;
	logic [NODES-1:0] hasp_q;
	logic [NODES-1:0] right_q;
	logic [CW-1:0] leaf_q;
	logic [NW-1:0] cur_q;
	logic [CODE_W-1:0] code_q;
	logic [NW-1:0] len_q;

	logic          o_valid_q, o_last_q, o_empty_q, o_ovf_q;
	logic [INDEX_W-1:0]  o_idx_q;
	logic [VALUE_W-1:0]  o_sym_q;
	logic [CODE_W-1:0]   o_code_q;
	logic [LENGTH_W-1:0] o_len_q;

	logic                s_fire;
	logic [WEIGHT_W-1:0] in_weight;
	logic [VALUE_W-1:0]  in_value;

	logic          w_we, w_re;
	logic [NW-1:0] w_waddr, w_raddr;
	logic [WW-1:0] w_wdata, w_rdata;
	logic          p_we, p_re;
	logic [NW-1:0] p_waddr, p_wdata, p_rdata;
	logic          y_we, y_re;
	logic [LW-1:0] y_waddr, y_raddr;
	logic [VALUE_W-1:0] y_rdata;

	logic          take;

	assign in_weight = s_axis_tdata[WEIGHT_W-1:0];
	assign in_value  = s_axis_tdata[WEIGHT_W +: VALUE_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;

	// Shared compare gate: is the node now read a parentless candidate for the best or second pick
	assign take = pend_q && !hasp_q[didx_q];

	// Memory port control
	always_comb begin
		w_we    = 1'b0;
		w_waddr = made_q;
		w_wdata = bw_q + sw_q;
		w_re    = 1'b0;
		w_raddr = addr_q;
		p_we    = 1'b0;
		p_waddr = bidx_q;
		p_wdata = made_q;
		p_re    = 1'b0;
		y_we    = 1'b0;
		y_waddr = count_q[LW-1:0];
		y_re    = 1'b0;
		y_raddr = leaf_q[LW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire && s_axis_tuser == ACT_LOAD && count_q < CW'(MAX_LEAVES)) begin
					w_we    = 1'b1;
					w_waddr = NW'(count_q);
					w_wdata = WW'(in_weight);
					y_we    = 1'b1;
				end
			end
			ST_SCAN: begin
				w_re = (addr_q < made_q);
			end
			ST_MERGE: begin
				w_we = 1'b1;
				p_we = 1'b1;
			end
			ST_MRG2: begin
				p_we    = 1'b1;
				p_waddr = sidx_q;
			end
			ST_LEAF: begin
				y_re = 1'b1;
			end
			ST_WRD: begin
				p_re = hasp_q[cur_q];
			end
			default: begin
			end
		endcase
	end

	hcb_ram #(.WIDTH(WW), .DEPTH(NODES)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata)
	);

	hcb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_parent (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(cur_q), .rdata(p_rdata)
	);

	hcb_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEAVES)) u_symbol (
		.clk(clk), .we(y_we), .waddr(y_waddr), .wdata(in_value),
		.re(y_re), .raddr(y_raddr), .rdata(y_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			o_valid_q <= 1'b0;
			pend_q    <= 1'b0;
			bvld_q    <= 1'b0;
			svld_q    <= 1'b0;
			hasp_q    <= '0;
			right_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_axis_tuser == ACT_LOAD) begin
							if (count_q < CW'(MAX_LEAVES)) begin
								count_q <= count_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (count_q == '0) begin
							o_idx_q   <= '0;
							o_sym_q   <= '0;
							o_code_q  <= '0;
							o_len_q   <= '0;
							o_empty_q <= 1'b1;
							o_ovf_q   <= ovf_q;
							o_last_q  <= 1'b1;
							o_valid_q <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							hasp_q   <= '0;
							right_q  <= '0;
							made_q   <= NW'(count_q);
							target_q <= NW'({count_q, 1'b0} - 1'b1);
							leaf_q   <= '0;
							addr_q   <= '0;
							pend_q   <= 1'b0;
							bvld_q   <= 1'b0;
							svld_q   <= 1'b0;
							state_q  <= (count_q == CW'(1)) ? ST_LEAF : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// advance the read address and track the two lightest nodes
					if (addr_q < made_q) begin
						addr_q <= addr_q + 1'b1;
						didx_q <= addr_q;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (take) begin
						if (!bvld_q || w_rdata < bw_q) begin
							sidx_q <= bidx_q;
							sw_q   <= bw_q;
							svld_q <= bvld_q;
							bidx_q <= didx_q;
							bw_q   <= w_rdata;
							bvld_q <= 1'b1;
						end else if (!svld_q || w_rdata < sw_q) begin
							sidx_q <= didx_q;
							sw_q   <= w_rdata;
							svld_q <= 1'b1;
						end
					end
					if (addr_q == made_q && !pend_q) begin
						state_q <= svld_q ? ST_MERGE : ST_LEAF;
					end
				end
				ST_MERGE: begin
					hasp_q[bidx_q]  <= 1'b1;
					right_q[bidx_q] <= 1'b0;
					state_q         <= ST_MRG2;
				end
				ST_MRG2: begin
					hasp_q[sidx_q]  <= 1'b1;
					right_q[sidx_q] <= 1'b1;
					made_q <= made_q + 1'b1;
					addr_q <= '0;
					bvld_q <= 1'b0;
					svld_q <= 1'b0;
					state_q <= (made_q + 1'b1 == target_q) ? ST_LEAF : ST_SCAN;
				end
				ST_LEAF: begin
					cur_q   <= NW'(leaf_q);
					code_q  <= '0;
					len_q   <= '0;
					state_q <= ST_WRD;
				end
				ST_WRD: begin
					if (hasp_q[cur_q]) begin
						state_q <= ST_WUSE;
					end else begin
						o_idx_q   <= INDEX_W'(leaf_q);
						o_sym_q   <= y_rdata;
						o_code_q  <= code_q;
						o_len_q   <= LENGTH_W'(len_q);
						o_empty_q <= 1'b0;
						o_ovf_q   <= ovf_q;
						o_last_q  <= (leaf_q + 1'b1 == count_q);
						o_valid_q <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_WUSE: begin
					// step one level up, recording the side taken
					if (right_q[cur_q] && len_q < NW'(CODE_W)) begin
						code_q[len_q[LENGTH_W-1:0]] <= 1'b1;
					end
					len_q   <= len_q + 1'b1;
					cur_q   <= p_rdata;
					state_q <= ST_WRD;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						o_valid_q <= 1'b0;
						if (o_last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							leaf_q  <= leaf_q + 1'b1;
							state_q <= ST_LEAF;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {5'b0, o_ovf_q, o_empty_q, o_len_q, o_code_q, o_sym_q, o_idx_q};

endmodule

// ===== design/hcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/hcb_checker.sv =====
// Port-level checks for the Huffman code builder, bound to the top level.
module hcb_checker
	import hcb_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata,
	input logic                m_axis_tlast
);

	// A stalled result holds its item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// No new input item is taken while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while a result is pending");

	// An empty build gives one final item with an empty code
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OFS_EMPTY] |->
			m_axis_tlast && m_axis_tdata[OFS_LENGTH +: LENGTH_W] == '0)
		else $error("empty build result malformed");

	// Only leaf index zero may carry the no-leaves flag
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OFS_EMPTY] |-> m_axis_tdata[INDEX_W-1:0] == '0)
		else $error("empty build result with nonzero index");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
